@@ src/tle_pkg.sv @@
// ----------------------------------------------------------------------------
// tle_pkg
// Shared types and constants of the terminal line editor: character codes,
// register indexes, controller states and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tle_pkg;

    localparam int LINE_SIZE_DEF = 32;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BELL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANSI = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_FIN_LO = 8'h41;
    localparam logic [7:0] CH_UP     = 8'h41;
    localparam logic [7:0] CH_DOWN   = 8'h42;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    typedef enum logic [1:0] {
        ESC_NONE = 2'd0,
        ESC_SEEN = 2'd1,
        ESC_CSI  = 2'd2
    } t_esc;

    typedef enum logic [2:0] {
        PH_BELL,
        PH_ECHO,
        PH_CR,
        PH_LF,
        PH_RUN
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DISPATCH,
        S_BELL,
        S_ECHO,
        S_CR,
        S_LF,
        S_RUN
    } t_state;

    typedef struct packed {
        logic   accept;
        logic   decode;
        logic   load;
        t_phase sel;
        logic   last;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic pl_bell;
        logic pl_echo;
        logic pl_crlf;
        logic pl_run;
        logic run_done;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ src/tle_ctrl.sv @@
// ----------------------------------------------------------------------------
// tle_ctrl
// Controller of the line editor. Takes a request, has the datapath decode it
// and then walks the output phases (bell, echo, CR, LF, run) that the plan
// calls for, one result per free output slot.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  tle_pkg::t_dp_sts i_sts,
    output tle_pkg::t_dp_cmd o_cmd,
    output logic             o_in_stall
);
    import tle_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (i_sts.pl_bell) begin
                    n_state = S_BELL;
                end else if (i_sts.pl_echo) begin
                    n_state = S_ECHO;
                end else if (i_sts.pl_crlf) begin
                    n_state = S_CR;
                end else if (i_sts.pl_run) begin
                    n_state = S_RUN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BELL: begin
                if (i_sts.out_free) begin
                    if (i_sts.pl_echo) begin
                        n_state = S_ECHO;
                    end else if (i_sts.pl_crlf) begin
                        n_state = S_CR;
                    end else if (i_sts.pl_run) begin
                        n_state = S_RUN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ECHO: begin
                if (i_sts.out_free) begin
                    if (i_sts.pl_crlf) begin
                        n_state = S_CR;
                    end else if (i_sts.pl_run) begin
                        n_state = S_RUN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CR: begin
                if (i_sts.out_free) begin
                    n_state = S_LF;
                end
            end
            S_LF: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.pl_run ? S_RUN : S_IDLE;
                end
            end
            S_RUN: begin
                if (i_sts.out_free && i_sts.run_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.sel    = PH_BELL;
        o_in_stall   = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
            end
            S_BELL: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.sel  = PH_BELL;
                o_cmd.last = !(i_sts.pl_echo || i_sts.pl_crlf || i_sts.pl_run);
            end
            S_ECHO: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.sel  = PH_ECHO;
                o_cmd.last = !(i_sts.pl_crlf || i_sts.pl_run);
            end
            S_CR: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.sel  = PH_CR;
            end
            S_LF: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.sel  = PH_LF;
                o_cmd.last = !i_sts.pl_run;
            end
            S_RUN: begin
                o_cmd.load = i_sts.out_free;
                o_cmd.sel  = PH_RUN;
                o_cmd.last = i_sts.run_done;
            end
            default: begin
                o_cmd.load = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/tle_dp.sv @@
// ----------------------------------------------------------------------------
// tle_dp
// Datapath of the line editor: configuration bits, line memory, write and
// recall indexes, escape tracking, the per-request output plan with its run
// counter, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tle_dp #(
    parameter int LINE_SIZE = tle_pkg::LINE_SIZE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tle_pkg::t_dp_cmd               i_cmd,
    output tle_pkg::t_dp_sts               o_sts,
    input  logic [7:0]                     i_byte_in,
    input  logic                           i_cfg_we,
    input  logic [tle_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic                           i_cfg_data,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic                           o_kind,
    output logic [7:0]                     o_data_byte,
    output logic                           o_end_of_command,
    output logic                           o_last
);
    import tle_pkg::*;

    localparam int IDX_W = $clog2(LINE_SIZE);
    localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(LINE_SIZE - 1);

    logic             r_echo_en;
    logic             r_bell_en;
    logic             r_ansi_en;
    logic [7:0]       r_byte;
    logic [IDX_W-1:0] r_wr;
    logic [IDX_W-1:0] r_rc;
    logic             r_prev_cr;
    t_esc             r_esc;

    logic             r_pl_bell;
    logic             r_pl_echo;
    logic             r_pl_crlf;
    logic             r_pl_run;
    logic             r_run_cmd;
    logic             r_run_del;
    logic [IDX_W-1:0] r_run_cnt;
    logic [IDX_W-1:0] r_run_end;
    logic [IDX_W-1:0] n_run_cnt;

    logic [7:0]       r_mem [LINE_SIZE];
    logic [7:0]       r_rd_data;

    logic             r_out_valid;
    logic             r_kind;
    logic [7:0]       r_data;
    logic             r_eoc;
    logic             r_last;

    // Decoded next values, taken when the controller issues decode.
    logic             d_mem_we;
    logic [IDX_W-1:0] d_wr;
    logic [IDX_W-1:0] d_rc;
    logic             d_prev_cr;
    t_esc             d_esc;
    logic             d_bell;
    logic             d_echo;
    logic             d_crlf;
    logic             d_run;
    logic             d_run_cmd;
    logic             d_run_del;
    logic [IDX_W-1:0] d_run_start;
    logic [IDX_W-1:0] d_run_end;

    logic [IDX_W-1:0] w_cnt_inc;
    logic             w_run_done;
    logic             w_out_free;

    assign w_cnt_inc  = r_run_cnt + IDX_W'(1);
    assign w_run_done = (w_cnt_inc == r_run_end);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        d_mem_we    = 1'b0;
        d_wr        = r_wr;
        d_rc        = r_rc;
        d_prev_cr   = r_prev_cr;
        d_esc       = r_esc;
        d_bell      = 1'b0;
        d_echo      = 1'b0;
        d_crlf      = 1'b0;
        d_run       = 1'b0;
        d_run_cmd   = 1'b0;
        d_run_del   = 1'b0;
        d_run_start = '0;
        d_run_end   = '0;
        case (r_esc)
            ESC_SEEN: begin
                d_esc = (r_byte == CH_LBRACK) ? ESC_CSI : ESC_NONE;
            end
            ESC_CSI: begin
                // Bytes outside the final range keep the sequence open.
                if (r_byte >= CH_FIN_LO && r_byte <= CH_DEL) begin
                    d_esc = ESC_NONE;
                    if (r_byte == CH_UP) begin
                        if (r_rc > r_wr) begin
                            d_run       = r_echo_en;
                            d_run_start = r_wr;
                            d_run_end   = r_rc;
                            d_wr        = r_rc;
                        end else begin
                            d_bell = r_bell_en;
                        end
                    end else if (r_byte == CH_DOWN) begin
                        if (r_wr != '0) begin
                            d_run     = r_echo_en;
                            d_run_del = 1'b1;
                            d_run_end = r_wr;
                            d_rc      = r_wr;
                            d_wr      = '0;
                        end else begin
                            d_bell = r_bell_en;
                        end
                    end else begin
                        d_bell = r_bell_en;
                    end
                end
            end
            default: begin
                d_prev_cr = (r_byte == CH_CR);
                if (r_byte == CH_LF && r_prev_cr) begin
                    d_echo = r_echo_en;
                end else if (r_byte == CH_LF || r_byte == CH_CR || r_byte == CH_NUL) begin
                    d_crlf    = r_echo_en;
                    d_run     = (r_wr != '0);
                    d_run_cmd = 1'b1;
                    d_run_end = r_wr;
                    d_wr      = '0;
                end else if (r_byte == CH_DEL) begin
                    if (r_wr != '0) begin
                        d_wr = r_wr - IDX_W'(1);
                    end else begin
                        d_bell = r_bell_en;
                    end
                    d_echo = r_echo_en;
                end else if (r_byte == CH_ESC && r_ansi_en) begin
                    d_esc = ESC_SEEN;
                end else begin
                    // A full line is thrown away rather than stored.
                    if (r_wr < IDX_FULL) begin
                        d_mem_we = 1'b1;
                        d_wr     = r_wr + IDX_W'(1);
                        d_rc     = r_wr + IDX_W'(1);
                    end else begin
                        d_wr = '0;
                        d_rc = '0;
                    end
                    d_echo = r_echo_en;
                end
            end
        endcase
    end

    always_comb begin
        if (i_cmd.decode) begin
            n_run_cnt = d_run_start;
        end else if (i_cmd.load && i_cmd.sel == PH_RUN) begin
            n_run_cnt = w_cnt_inc;
        end else begin
            n_run_cnt = r_run_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo_en <= 1'b0;
            r_bell_en <= 1'b0;
            r_ansi_en <= 1'b1;
            r_wr      <= '0;
            r_rc      <= '0;
            r_prev_cr <= 1'b0;
            r_esc     <= ESC_NONE;
            r_pl_bell <= 1'b0;
            r_pl_echo <= 1'b0;
            r_pl_crlf <= 1'b0;
            r_pl_run  <= 1'b0;
            r_run_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ECHO: r_echo_en <= i_cfg_data;
                    CFG_BELL: r_bell_en <= i_cfg_data;
                    CFG_ANSI: r_ansi_en <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.decode) begin
                r_wr      <= d_wr;
                r_rc      <= d_rc;
                r_prev_cr <= d_prev_cr;
                r_esc     <= d_esc;
                r_pl_bell <= d_bell;
                r_pl_echo <= d_echo;
                r_pl_crlf <= d_crlf;
                r_pl_run  <= d_run;
            end
            r_run_cnt <= n_run_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_byte <= i_byte_in;
        end
        if (i_cmd.decode) begin
            r_run_cmd <= d_run_cmd;
            r_run_del <= d_run_del;
            r_run_end <= d_run_end;
        end
    end

    // Line memory: one write port, one registered read port that follows
    // the next run position so the data is ready when the run reaches it.
    always_ff @(posedge i_clk) begin
        if (i_cmd.decode && d_mem_we) begin
            r_mem[r_wr] <= r_byte;
        end
        r_rd_data <= r_mem[n_run_cnt];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_last <= i_cmd.last;
            case (i_cmd.sel)
                PH_BELL: begin
                    r_kind <= 1'b0;
                    r_data <= CH_BEL;
                    r_eoc  <= 1'b0;
                end
                PH_ECHO: begin
                    r_kind <= 1'b0;
                    r_data <= r_byte;
                    r_eoc  <= 1'b0;
                end
                PH_CR: begin
                    r_kind <= 1'b0;
                    r_data <= CH_CR;
                    r_eoc  <= 1'b0;
                end
                PH_LF: begin
                    r_kind <= 1'b0;
                    r_data <= CH_LF;
                    r_eoc  <= 1'b0;
                end
                PH_RUN: begin
                    r_kind <= r_run_cmd;
                    r_data <= r_run_del ? CH_DEL : r_rd_data;
                    r_eoc  <= r_run_cmd && w_run_done;
                end
                default: begin
                    r_kind <= 1'b0;
                    r_data <= CH_BEL;
                    r_eoc  <= 1'b0;
                end
            endcase
        end
    end

    assign o_sts.out_free = w_out_free;
    assign o_sts.pl_bell  = r_pl_bell;
    assign o_sts.pl_echo  = r_pl_echo;
    assign o_sts.pl_crlf  = r_pl_crlf;
    assign o_sts.pl_run   = r_pl_run;
    assign o_sts.run_done = w_run_done;

    assign o_out_valid      = r_out_valid;
    assign o_kind           = r_kind;
    assign o_data_byte      = r_data;
    assign o_end_of_command = r_eoc;
    assign o_last           = r_last;

endmodule

`default_nettype wire

@@ src/terminal_line_editor_core.sv @@
// Operation: a request is accepted, decoded and dispatched, then its results are loaded into the
// output register. A new request is taken only once the previous one is finished; results leave
// one per cycle through the output register while the output is not stalled, run characters read
// from the single read port of the line memory.
// Reset: synchronous, active low; clears indexes, escape tracking and configuration
// (echo and bell off, escape sequences on). The line memory is not cleared.
// ----------------------------------------------------------------------------
// terminal_line_editor_core
// Terminal line editor with history recall: stores typed characters, handles
// delete, line ends and up/down escape sequences, and emits echo bytes and
// completed command characters.
// ----------------------------------------------------------------------------
`default_nettype none

module terminal_line_editor_core #(
    parameter int LINE_SIZE = tle_pkg::LINE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [7:0]                    i_byte_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_kind,
    output logic [7:0]                    o_data_byte,
    output logic                          o_end_of_command,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [tle_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                          i_cfg_data
);
    import tle_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    tle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    tle_dp #(
        .LINE_SIZE (LINE_SIZE)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_byte_in        (i_byte_in),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_end_of_command (o_end_of_command),
        .o_last           (o_last)
    );

    // A request is worked on alone: the input closes right after acceptance.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted twice in a row");

    // End of command only marks the final command character of a request.
    a_eoc_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_command) |-> (o_kind && o_last))
        else $error("end of command on a non-final or terminal result");

    // The output register is only loaded while a request is being worked on.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> o_in_stall)
        else $error("result produced while idle");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for terminal_line_editor_core. A short table of
// keystrokes exercises bell, echo, line ends and escape sequences. It is
// followed by random typed lines, deletes, recall sequences and noise under
// several register settings and stall patterns. Every result is compared with
// a line editor model kept inside the bench, or with the results a table row gives.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import tle_pkg::*;

    localparam int LINE_SIZE     = LINE_SIZE_DEF;
    localparam int SETTLE_CYCLES = LINE_SIZE + 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SEGMENT_ITEMS = 50;

    // Index 3 is not a register; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic KIND_TERM = 1'b0;
    localparam logic KIND_CMD  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data;
        logic       eoc;
        logic       last;
    } t_edit_result;

    typedef enum logic [1:0] {
        ROW_KEY,
        ROW_KEY_TYPED,
        ROW_REG
    } t_row_op;

    typedef struct packed {
        t_row_op              op;
        logic [7:0]           value;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [1:0]           n_typed;
        t_edit_result         typed0;
        t_edit_result         typed1;
    } t_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [7:0]           i_byte_in;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_kind;
    logic [7:0]           o_data_byte;
    logic                 o_end_of_command;
    logic                 o_last;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic                 i_cfg_data;

    // Model state of the line editor.
    logic [7:0]   line_copy [LINE_SIZE];
    int           wr_pos;
    int           recall_pos;
    logic [7:0]   prior_byte;
    t_esc         esc_mode;
    logic         echo_on;
    logic         bell_on;
    logic         ansi_on;

    t_edit_result keystroke_out[$];
    t_edit_result awaited_results[$];
    logic [7:0]   burst[$];
    t_row         directed[$];

    int in_idle_pct  = 21;
    int out_idle_pct = 72;
    int hold_asks    = 0;
    int failures     = 0;

    terminal_line_editor_core #(
        .LINE_SIZE(LINE_SIZE)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_byte_in       (i_byte_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_data_byte     (o_data_byte),
        .o_end_of_command(o_end_of_command),
        .o_last          (o_last),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_edit_result res(input logic kind, input logic [7:0] data,
                                         input logic eoc, input logic last);
        t_edit_result r;
        r.kind = kind;
        r.data = data;
        r.eoc  = eoc;
        r.last = last;
        return r;
    endfunction

    function automatic t_row key(input logic [7:0] b);
        t_row r;
        r = '0;
        r.op = ROW_KEY;
        r.value = b;
        return r;
    endfunction

    function automatic t_row key_typed(input logic [7:0] b, input logic [1:0] n,
                                       input t_edit_result r0, input t_edit_result r1);
        t_row r;
        r = '0;
        r.op = ROW_KEY_TYPED;
        r.value = b;
        r.n_typed = n;
        r.typed0 = r0;
        r.typed1 = r1;
        return r;
    endfunction

    function automatic t_row reg_row(input logic [CFG_IDX_W-1:0] idx, input logic val);
        t_row r;
        r = '0;
        r.op = ROW_REG;
        r.reg_index = idx;
        r.value = {7'd0, val};
        return r;
    endfunction

    function automatic void emit(input logic kind, input logic [7:0] data, input logic eoc);
        keystroke_out.push_back(res(kind, data, eoc, 1'b0));
    endfunction

    function automatic void ring();
        if (bell_on)
            emit(KIND_TERM, CH_BEL, 1'b0);
    endfunction

    // Works out the results of one received byte and advances the model.
    function automatic void keystroke_effect(input logic [7:0] ch);
        t_edit_result tail;
        int           i;
        keystroke_out.delete();
        if (esc_mode == ESC_SEEN) begin
            if (ch == CH_LBRACK)
                esc_mode = ESC_CSI;
            else
                esc_mode = ESC_NONE;
        end else if (esc_mode == ESC_CSI) begin
            // Bytes below the final range are swallowed and keep the sequence open.
            if (ch >= CH_FIN_LO && ch <= CH_DEL) begin
                if (ch == CH_UP) begin
                    if (recall_pos > wr_pos) begin
                        if (echo_on)
                            for (i = wr_pos; i < recall_pos; i++)
                                emit(KIND_TERM, line_copy[i], 1'b0);
                        wr_pos = recall_pos;
                    end else begin
                        ring();
                    end
                end else if (ch == CH_DOWN) begin
                    if (wr_pos > 0) begin
                        if (echo_on)
                            for (i = 0; i < wr_pos; i++)
                                emit(KIND_TERM, CH_DEL, 1'b0);
                        recall_pos = wr_pos;
                        wr_pos = 0;
                    end else begin
                        ring();
                    end
                end else begin
                    ring();
                end
                esc_mode = ESC_NONE;
            end
        end else begin
            if (ch == CH_LF && prior_byte == CH_CR) begin
                if (echo_on)
                    emit(KIND_TERM, CH_LF, 1'b0);
            end else if (ch == CH_LF || ch == CH_CR || ch == CH_NUL) begin
                if (echo_on) begin
                    emit(KIND_TERM, CH_CR, 1'b0);
                    emit(KIND_TERM, CH_LF, 1'b0);
                end
                for (i = 0; i < wr_pos; i++)
                    emit(KIND_CMD, line_copy[i], i + 1 == wr_pos);
                wr_pos = 0;
            end else if (ch == CH_DEL) begin
                if (wr_pos > 0)
                    wr_pos--;
                else
                    ring();
                if (echo_on)
                    emit(KIND_TERM, CH_DEL, 1'b0);
            end else if (ch == CH_ESC && ansi_on) begin
                esc_mode = ESC_SEEN;
            end else begin
                // A full buffer throws the whole line away.
                if (wr_pos < LINE_SIZE - 1) begin
                    line_copy[wr_pos] = ch;
                    wr_pos++;
                end else begin
                    wr_pos = 0;
                end
                recall_pos = wr_pos;
                if (echo_on)
                    emit(KIND_TERM, ch, 1'b0);
            end
            prior_byte = ch;
        end
        if (keystroke_out.size() > 0) begin
            tail = keystroke_out.pop_back();
            tail.last = 1'b1;
            keystroke_out.push_back(tail);
        end
    endfunction

    // Drops the request line and waits until the block has nothing left to say.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (awaited_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ECHO: echo_on = val;
            CFG_BELL: bell_on = val;
            CFG_ANSI: ansi_on = val;
            default: ;
        endcase
    endtask

    // Offers one byte, waits for acceptance and queues what it should cause.
    // The request line is left high so that back-to-back bytes need no gap.
    task automatic send_row(input t_row row);
        int gap;
        int k;
        gap = 0;
        while ($urandom_range(99) < in_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_in  <= row.value;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        keystroke_effect(row.value);
        if (row.op == ROW_KEY_TYPED) begin
            if (row.n_typed > 0)
                awaited_results.push_back(row.typed0);
            if (row.n_typed > 1)
                awaited_results.push_back(row.typed1);
        end else begin
            for (k = 0; k < keystroke_out.size(); k++)
                awaited_results.push_back(keystroke_out[k]);
        end
    endtask

    // Mostly well-formed lines and escape sequences, with some noise.
    task automatic make_burst();
        int pick;
        int len;
        int j;
        burst.delete();
        pick = $urandom_range(99);
        if (pick < 45) begin
            if ($urandom_range(7) == 0)
                len = $urandom_range(LINE_SIZE - 4, LINE_SIZE + 2);
            else
                len = $urandom_range(8);
            for (j = 0; j < len; j++) begin
                pick = $urandom_range(99);
                if (pick < 85)
                    burst.push_back(8'($urandom_range(8'h20, 8'h7E)));
                else if (pick < 95)
                    burst.push_back(CH_DEL);
                else
                    burst.push_back(8'($urandom_range(8'h80, 8'hFF)));
            end
            case ($urandom_range(3))
                0: burst.push_back(CH_CR);
                1: burst.push_back(CH_LF);
                2: burst.push_back(CH_NUL);
                default: begin
                    burst.push_back(CH_CR);
                    burst.push_back(CH_LF);
                end
            endcase
        end else if (pick < 65) begin
            burst.push_back(CH_ESC);
            burst.push_back(CH_LBRACK);
            if ($urandom_range(99) < 20) begin
                if ($urandom_range(1) == 0)
                    burst.push_back(8'($urandom_range(8'h40)));
                else
                    burst.push_back(8'($urandom_range(8'h80, 8'hFF)));
            end
            pick = $urandom_range(99);
            if (pick < 45)
                burst.push_back(CH_UP);
            else if (pick < 80)
                burst.push_back(CH_DOWN);
            else
                burst.push_back(8'($urandom_range(CH_FIN_LO, CH_DEL)));
        end else if (pick < 75) begin
            burst.push_back(CH_ESC);
            burst.push_back(8'($urandom));
        end else if (pick < 85) begin
            repeat ($urandom_range(1, 4)) burst.push_back(CH_DEL);
        end else begin
            repeat ($urandom_range(1, 4)) burst.push_back(8'($urandom));
        end
    endtask

    initial begin : receiver
        int           hold_left;
        int           hold_seen;
        t_edit_result want;
        t_edit_result got;
        hold_left = 0;
        hold_seen = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got = res(o_kind, o_data_byte, o_end_of_command, o_last);
                if (awaited_results.size() == 0) begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected result: kind %0d data %02h eoc %0d last %0d",
                                 got.kind, got.data, got.eoc, got.last);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.kind !== want.kind || got.data !== want.data ||
                        got.eoc !== want.eoc || got.last !== want.last) begin
                        failures++;
                        if (failures <= 10)
                            $display({"result mismatch: expected kind %0d data %02h eoc %0d ",
                                      "last %0d, got kind %0d data %02h eoc %0d last %0d"},
                                     want.kind, want.data, want.eoc, want.last,
                                     got.kind, got.data, got.eoc, got.last);
                    end
                end
            end
            if (hold_seen != hold_asks) begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < out_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial begin : stimulus
        int         seg;
        int         sent;
        int         k;
        logic [2:0] setting;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_byte_in   <= CH_NUL;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_ECHO;
        i_cfg_data  <= 1'b0;

        for (k = 0; k < LINE_SIZE; k++)
            line_copy[k] = 8'h00;
        wr_pos     = 0;
        recall_pos = 0;
        prior_byte = CH_NUL;
        esc_mode   = ESC_NONE;
        echo_on    = 1'b0;
        bell_on    = 1'b0;
        ansi_on    = 1'b1;

        directed.push_back(reg_row(CFG_ECHO, 1'b1));
        directed.push_back(reg_row(CFG_BELL, 1'b1));
        // Delete on an empty line rings the bell and is still echoed.
        directed.push_back(key_typed(CH_DEL, 2'd2, res(KIND_TERM, CH_BEL, 1'b0, 1'b0),
                                     res(KIND_TERM, CH_DEL, 1'b0, 1'b1)));
        directed.push_back(key_typed(8'h61, 2'd1, res(KIND_TERM, 8'h61, 1'b0, 1'b1), '0));
        directed.push_back(key_typed(8'hFF, 2'd1, res(KIND_TERM, 8'hFF, 1'b0, 1'b1), '0));
        directed.push_back(key(CH_CR));
        // A line feed right after a carriage return is only echoed.
        directed.push_back(key_typed(CH_LF, 2'd1, res(KIND_TERM, CH_LF, 1'b0, 1'b1), '0));
        directed.push_back(key_typed(CH_NUL, 2'd2, res(KIND_TERM, CH_CR, 1'b0, 1'b0),
                                     res(KIND_TERM, CH_LF, 1'b0, 1'b1)));
        directed.push_back(key(8'h78));
        directed.push_back(key(8'h79));
        directed.push_back(key(CH_DEL));
        directed.push_back(key(CH_ESC));
        directed.push_back(key(CH_LBRACK));
        directed.push_back(key(CH_UP));
        directed.push_back(key(CH_ESC));
        directed.push_back(key(CH_LBRACK));
        directed.push_back(key(CH_DOWN));
        directed.push_back(key(CH_ESC));
        directed.push_back(key(8'h51));
        directed.push_back(key(CH_ESC));
        directed.push_back(key(CH_LBRACK));
        directed.push_back(key(8'h20));
        directed.push_back(key(8'h43));
        // Turning escape handling off inside a sequence lets it finish.
        directed.push_back(key(CH_ESC));
        directed.push_back(reg_row(CFG_ANSI, 1'b0));
        directed.push_back(key(CH_LBRACK));
        directed.push_back(key(CH_DOWN));
        directed.push_back(key_typed(CH_ESC, 2'd1, res(KIND_TERM, CH_ESC, 1'b0, 1'b1), '0));
        directed.push_back(key(CH_CR));
        directed.push_back(reg_row(CFG_SPARE, 1'b1));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[row_i]) begin
            if (directed[row_i].op == ROW_REG)
                write_reg(directed[row_i].reg_index, directed[row_i].value[0]);
            else
                send_row(directed[row_i]);
        end

        for (seg = 0; seg < 8; seg++) begin
            if (seg < 3) begin
                in_idle_pct  = 21;
                out_idle_pct = 72;
            end else if (seg < 6) begin
                in_idle_pct  = 72;
                out_idle_pct = 21;
            end else begin
                in_idle_pct  = 0;
                out_idle_pct = 0;
            end
            // Walks through all eight settings; all off and all on included.
            setting = 3'(seg) ^ 3'b001;
            write_reg(CFG_ECHO, setting[0]);
            write_reg(CFG_BELL, setting[1]);
            write_reg(CFG_ANSI, setting[2]);
            if (seg == 4)
                write_reg(CFG_SPARE, 1'b0);
            // Long output hold while requests keep coming, so the block backs up.
            if (seg == 6)
                hold_asks++;
            sent = 0;
            while (sent < SEGMENT_ITEMS) begin
                make_burst();
                foreach (burst[byte_i])
                    send_row(key(burst[byte_i]));
                if (seg == 2 && sent < SEGMENT_ITEMS / 2 &&
                    sent + burst.size() >= SEGMENT_ITEMS / 2)
                    settle();
                sent += burst.size();
            end
        end

        settle();
        if (failures == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
src/tle_pkg.sv
src/tle_ctrl.sv
src/tle_dp.sv
src/terminal_line_editor_core.sv
tb/testbench.sv
